>>> src/ssr_pkg.sv
// Shared constants and types of the streaming substring replace block.
package ssr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

    // Attributes shared by every result of one buffered burst.
    typedef struct packed {
        logic data;   // results carry bytes; clear for a bare end marker
        logic last;   // the final result of the burst ends the string
    } burst_ctrl_t;

endpackage

>>> src/ssr_chan_if.sv
// Valid/ready channel interfaces for text items and result items.
interface ssr_text_if;
    logic                       valid;
    logic                       ready;
    logic [ssr_pkg::BYTE_W-1:0] in_byte;
    logic                       in_valid;
    logic                       in_last;

    modport source (output valid, output in_byte, output in_valid, output in_last,
                     input ready);
    modport sink   (input valid, input in_byte, input in_valid, input in_last,
                     output ready);
endinterface

interface ssr_result_if;
    logic                       valid;
    logic                       ready;
    logic [ssr_pkg::BYTE_W-1:0] out_byte;
    logic                       out_valid;
    logic                       out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                     input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                     output ready);
endinterface

>>> src/ssr_burst_out.sv
// Result buffer that holds one burst of results and hands them out one per cycle while res_ready is high.
module ssr_burst_out #(
    parameter int DEPTH = 8,
    parameter int CNT_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [ssr_pkg::BYTE_W-1:0] load_bytes [DEPTH],
    input  logic [CNT_W-1:0]           load_count,
    input  ssr_pkg::burst_ctrl_t       load_ctrl,
    output logic                       can_load,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [ssr_pkg::BYTE_W-1:0] res_byte,
    output logic                       res_data,
    output logic                       res_last
);

    logic [ssr_pkg::BYTE_W-1:0] bytes_reg [DEPTH];
    logic [ssr_pkg::BYTE_W-1:0] bytes_next [DEPTH];
    logic [CNT_W-1:0]           remain_reg;
    logic [CNT_W-1:0]           remain_next;
    ssr_pkg::burst_ctrl_t       ctrl_reg;
    ssr_pkg::burst_ctrl_t       ctrl_next;
    logic                       take;

    assign res_valid = (remain_reg != '0);
    assign take      = res_valid && res_ready;
    // A new burst may enter when the buffer is empty or its final result leaves now.
    assign can_load  = (remain_reg == '0) || ((remain_reg == CNT_W'(1)) && res_ready);
    assign res_byte  = bytes_reg[0];
    assign res_data  = ctrl_reg.data;
    assign res_last  = ctrl_reg.last && (remain_reg == CNT_W'(1));

    always_comb
    begin
        bytes_next  = bytes_reg;
        remain_next = remain_reg;
        ctrl_next   = ctrl_reg;
        if (load)
        begin
            bytes_next  = load_bytes;
            remain_next = load_count;
            ctrl_next   = load_ctrl;
        end
        else if (take)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i + 1];
            end
            bytes_next[DEPTH - 1] = '0;
            remain_next = remain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            ctrl_reg   <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

>>> src/stream_substring_replace.sv
// The first result of an item appears in the cycle after the item is accepted.
// Throughput: one item per cycle while each item gives at most one result and
// result.ready is high; an item that gives more results holds the result buffer
// until its final result leaves. The single-burst result buffer sets this rate.
// Reset clears the configuration registers, the window and the result buffer.
module stream_substring_replace #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ssr_text_if.sink                        text,
    ssr_result_if.source                    result,
    input  logic                            cfg_write,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int BW     = ssr_pkg::BYTE_W;
    localparam int LW     = ssr_pkg::LEN_W;
    localparam int MAXB   = MAX_PATTERN_BYTES;
    localparam int FILL_W = $clog2(MAXB + 1);
    localparam int IDX_W  = (MAXB > 1) ? $clog2(MAXB) : 1;

    // Configuration registers. Only the bytes that the window can hold are kept.
    logic [MAXB*BW-1:0] pattern_reg;
    logic [LW-1:0]      pattern_length_reg;
    logic [MAXB*BW-1:0] replacement_reg;
    logic [LW-1:0]      replacement_length_reg;

    // Sliding window: oldest byte at entry 0, fill_reg bytes valid.
    logic [BW-1:0]     window_reg [MAXB];
    logic [BW-1:0]     window_next [MAXB];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    // Per-item work signals.
    logic              item;
    logic [LW-1:0]     plen;
    logic [LW-1:0]     rlen;
    logic [BW-1:0]     win_app [MAXB];
    logic [FILL_W-1:0] fill_app;
    logic              bytes_equal;
    logic              match;
    logic              emit_oldest;

    // Burst handed to the result buffer.
    logic [BW-1:0]         burst_bytes [MAXB];
    logic [FILL_W-1:0]     burst_count;
    ssr_pkg::burst_ctrl_t  burst_ctrl;
    logic                  burst_load;
    logic                  can_load;

    assign item = text.valid && text.ready;
    assign text.ready = can_load;

    // Lengths above the window size saturate to it.
    assign plen = (pattern_length_reg > LW'(MAXB)) ? LW'(MAXB) : pattern_length_reg;
    assign rlen = (replacement_length_reg > LW'(MAXB)) ? LW'(MAXB) : replacement_length_reg;

    // Append the incoming byte, then decide between a match, a single emission
    // of the oldest byte, or waiting for more bytes.
    always_comb
    begin
        win_app  = window_reg;
        fill_app = fill_reg;
        if (text.in_valid && (fill_reg < FILL_W'(MAXB)))
        begin
            win_app[fill_reg[IDX_W-1:0]] = text.in_byte;
            fill_app = fill_reg + FILL_W'(1);
        end

        // Entries past the pattern length take no part in the compare.
        bytes_equal = 1'b1;
        for (int i = 0; i < MAXB; i++)
        begin
            if ((LW'(i) < plen) && (win_app[i] != pattern_reg[i*BW +: BW]))
            begin
                bytes_equal = 1'b0;
            end
        end

        // A compare is only made when the window holds exactly the pattern length;
        // a longer window (pattern shortened mid-string) just drains.
        match       = text.in_valid && (plen != '0) && (LW'(fill_app) == plen) && bytes_equal;
        emit_oldest = text.in_valid && (LW'(fill_app) >= plen) && !match;
    end

    // Next window contents.
    always_comb
    begin
        window_next = win_app;
        fill_next   = fill_app;
        if (match || text.in_last)
        begin
            for (int i = 0; i < MAXB; i++)
            begin
                window_next[i] = '0;
            end
            fill_next = '0;
        end
        else if (emit_oldest)
        begin
            for (int i = 0; i < MAXB - 1; i++)
            begin
                window_next[i] = win_app[i + 1];
            end
            window_next[MAXB - 1] = '0;
            fill_next = fill_app - FILL_W'(1);
        end
    end

    // Build the burst of results for this item. Without a match the results are
    // always a prefix of the window after the append: the oldest byte alone, or on
    // the last item the whole window (the popped byte followed by the flush).
    always_comb
    begin
        burst_ctrl.data = 1'b1;
        burst_ctrl.last = text.in_last;
        if (match)
        begin
            for (int i = 0; i < MAXB; i++)
            begin
                burst_bytes[i] = replacement_reg[i*BW +: BW];
            end
            burst_count = FILL_W'(rlen);
        end
        else
        begin
            burst_bytes = win_app;
            if (text.in_last)
            begin
                burst_count = fill_app;
            end
            else if (emit_oldest)
            begin
                burst_count = FILL_W'(1);
            end
            else
            begin
                burst_count = '0;
            end
        end

        // A string end with nothing to show still gives one bare end marker.
        if (text.in_last && (burst_count == '0))
        begin
            for (int i = 0; i < MAXB; i++)
            begin
                burst_bytes[i] = '0;
            end
            burst_count     = FILL_W'(1);
            burst_ctrl.data = 1'b0;
        end

        burst_load = item && (burst_count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg            <= '0;
            pattern_length_reg     <= '0;
            replacement_reg        <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ssr_pkg::CFG_PATTERN_BYTES:      pattern_reg            <= cfg_data[MAXB*BW-1:0];
                ssr_pkg::CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[LW-1:0];
                ssr_pkg::CFG_REPLACEMENT_BYTES:  replacement_reg        <= cfg_data[MAXB*BW-1:0];
                ssr_pkg::CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[LW-1:0];
                default:                         pattern_reg            <= pattern_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < MAXB; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (item)
        begin
            fill_reg   <= fill_next;
            window_reg <= window_next;
        end
    end

    // The result buffer parts the two handshakes and serializes each burst.
    ssr_burst_out #(
        .DEPTH (MAXB),
        .CNT_W (FILL_W)
    ) u_burst_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (burst_load),
        .load_bytes (burst_bytes),
        .load_count (burst_count),
        .load_ctrl  (burst_ctrl),
        .can_load   (can_load),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res_byte   (result.out_byte),
        .res_data   (result.out_valid),
        .res_last   (result.out_last)
    );

    // Between items the window never fills to its capacity of MAXB bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(MAXB))
        else $error("window fill reached its capacity between items");

    // The end of a string always leaves the window empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item && text.in_last) |=> (fill_reg == '0))
        else $error("window not empty after a string end");

    // A result without a byte is always a bare end marker with a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.out_valid) |-> (result.out_last && (result.out_byte == '0)))
        else $error("result without a byte is not a clean end marker");

    // An item is only taken when its burst can enter the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready && !result.out_last) |-> !text.ready)
        else $error("item accepted while a burst is still pending");

endmodule
